// ===== hw/rtl/lcd4_pkg.sv =====
// ----------------------------------------------------------------------------
// lcd4_pkg: shared types and constants for the 4-bit character LCD sequencer
// Request codes, register indexes, timing constants and the table of
// power-up initialization phases.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd4_pkg;

  // Request codes
  localparam logic [1:0] FUNC_INSTR = 2'd0;
  localparam logic [1:0] FUNC_CHAR  = 2'd1;
  localparam logic [1:0] FUNC_INIT  = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_POST_WAIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE     = 2'd1;

  localparam logic [15:0] POST_WAIT_RESET = 16'd80;
  localparam logic [7:0]  PULSE_RESET     = 8'd1;

  // LCD instructions used by the initialization run
  localparam logic [7:0] CMD_RESET    = 8'h30;
  localparam logic [7:0] CMD_FUNC4BIT = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;

  // Waits in microseconds
  localparam int WAIT_W = 17;
  localparam logic [WAIT_W-1:0] WAIT_POWERUP = 17'd100000;
  localparam logic [WAIT_W-1:0] WAIT_RESET1  = 17'd10000;
  localparam logic [WAIT_W-1:0] WAIT_RESET23 = 17'd200;
  localparam logic [WAIT_W-1:0] WAIT_CMD     = 17'd80;
  localparam logic [WAIT_W-1:0] WAIT_CLEAR   = 17'd4000;

  // Phase counting
  localparam int PHASE_W = 5;
  localparam logic [PHASE_W-1:0] BYTE_LAST    = 5'd3;
  localparam logic [PHASE_W-1:0] INIT_LAST    = 5'd28;
  localparam logic [PHASE_W-1:0] INIT_NIB_END = 5'd9;

  // Controller to datapath commands
  typedef struct packed {
    logic               start;  // request accepted, load its first phase
    logic               load;   // load the output register
    logic [PHASE_W-1:0] phase;  // phase index within the run
    logic               last;   // this phase closes the run
  } lcd4_cmd_t;

  // One initialization phase
  typedef struct packed {
    logic              powerup;
    logic [3:0]        nibble;
    logic              enable;
    logic [WAIT_W-1:0] extra;
  } init_step_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] j);
    logic [7:0] c;
    case (j)
      3'd0:    c = CMD_FUNC4BIT;
      3'd1:    c = CMD_DISP_OFF;
      3'd2:    c = CMD_CLEAR;
      3'd3:    c = CMD_ENTRY;
      default: c = CMD_DISP_ON;
    endcase
    return c;
  endfunction

  function automatic init_step_t init_step(input logic [PHASE_W-1:0] p);
    init_step_t       s;
    logic [PHASE_W-1:0] q;
    logic [7:0]       c;
    s = '0;
    if (p == '0) begin
      // power-up hold
      s.powerup = 1'b1;
    end else if (p < INIT_NIB_END) begin
      // single-nibble resets and 4-bit select
      q = p - 5'd1;
      s.nibble = (q[2:1] == 2'd3) ? CMD_FUNC4BIT[7:4] : CMD_RESET[7:4];
      s.enable = ~q[0];
      if (q[0]) begin
        case (q[2:1])
          2'd0:    s.extra = WAIT_RESET1;
          2'd1:    s.extra = WAIT_RESET23;
          2'd2:    s.extra = WAIT_RESET23;
          default: s.extra = WAIT_CMD;
        endcase
      end
    end else begin
      // full instructions, four phases each
      q = p - INIT_NIB_END;
      c = init_cmd(q[4:2]);
      s.nibble = q[1] ? c[3:0] : c[7:4];
      s.enable = ~q[0];
      if (q[1:0] == 2'd3) begin
        s.extra = (q[4:2] == 3'd2) ? WAIT_CLEAR : WAIT_CMD;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcd4_ifs.sv =====
// ----------------------------------------------------------------------------
// lcd4_ifs: channel interfaces of the 4-bit character LCD sequencer
// Request channel, pin-phase result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcd4_req_if import lcd4_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] value;
  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface lcd4_phase_if import lcd4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              reg_select;
  logic [3:0]        nibble;
  logic              enable;
  logic [WAIT_W-1:0] wait_us;
  logic              last;
  modport source (output valid, output reg_select, output nibble, output enable,
                  output wait_us, output last, input ready);
  modport sink   (input valid, input reg_select, input nibble, input enable,
                  input wait_us, input last, output ready);
endinterface

interface lcd4_cfg_if import lcd4_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcd4_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcd4_ctrl: sequencer controller
// Accepts requests, counts phases of the run and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_ctrl import lcd4_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire logic [1:0] req_func,
  output logic            req_ready,
  input  wire logic       out_ready,
  output logic            out_valid,
  output lcd4_cmd_t       cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic               state;
  logic               mode_init;
  logic [PHASE_W-1:0] count;
  logic               out_free;
  logic               accept;
  logic               step;
  logic [PHASE_W-1:0] last_idx;

  // Output register free when empty or being drained
  assign out_free  = ~out_valid | out_ready;
  assign req_ready = (state == S_IDLE) & out_free;
  assign accept    = req_valid & req_ready;
  assign step      = (state == S_RUN) & out_free;
  assign last_idx  = mode_init ? INIT_LAST : BYTE_LAST;

  // Issue datapath commands; the unused code is taken and dropped
  always_comb begin
    cmd.start = accept & ((req_func == FUNC_INSTR) | (req_func == FUNC_CHAR) |
                          (req_func == FUNC_INIT));
    cmd.load  = cmd.start | step;
    cmd.phase = cmd.start ? '0 : count;
    cmd.last  = step & (count == last_idx);
  end

  // Advance the run
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode_init <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            state     <= S_RUN;
            count     <= 5'd1;
            mode_init <= (req_func == FUNC_INIT);
          end
        end
        S_RUN: begin
          if (step) begin
            if (count == last_idx) begin
              state <= S_IDLE;
              count <= '0;
            end else begin
              count <= count + 5'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcd4_dp.sv =====
// ----------------------------------------------------------------------------
// lcd4_dp: sequencer datapath
// Holds the configuration registers and the request, builds each pin phase
// and registers it for the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_dp import lcd4_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [1:0]             req_func,
  input  wire logic [7:0]             req_value,
  input  wire lcd4_cmd_t              cmd,
  output logic                        reg_select,
  output logic [3:0]                  nibble,
  output logic                        enable,
  output logic [WAIT_W-1:0]           wait_us,
  output logic                        last
);

  logic [15:0]       post_wait;
  logic [7:0]        pulse;
  logic              init_q;
  logic              rs_q;
  logic [7:0]        value_q;
  logic              sel_init;
  logic              sel_rs;
  logic [7:0]        sel_value;
  init_step_t        ist;
  logic [WAIT_W-1:0] pulse_ext;
  logic [WAIT_W-1:0] extra;
  logic [3:0]        nib_c;
  logic              en_c;
  logic [WAIT_W-1:0] wait_c;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      post_wait <= POST_WAIT_RESET;
      pulse     <= PULSE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POST_WAIT: post_wait <= cfg_data;
        REG_PULSE:     pulse     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Hold the request for the rest of its run
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      init_q  <= (req_func == FUNC_INIT);
      rs_q    <= req_func[0];
      value_q <= req_value;
    end
  end

  // First phase comes straight from the request
  assign sel_init  = cmd.start ? (req_func == FUNC_INIT) : init_q;
  assign sel_rs    = cmd.start ? req_func[0] : rs_q;
  assign sel_value = cmd.start ? req_value : value_q;
  assign ist       = init_step(cmd.phase);
  assign pulse_ext = {{(WAIT_W-8){1'b0}}, pulse};

  // Build the phase fields
  always_comb begin
    if (sel_init) begin
      nib_c = ist.nibble;
      en_c  = ist.enable;
      extra = ist.extra;
    end else begin
      nib_c = cmd.phase[1] ? sel_value[3:0] : sel_value[7:4];
      en_c  = ~cmd.phase[0];
      extra = (cmd.phase == BYTE_LAST) ? {{(WAIT_W-16){1'b0}}, post_wait} : '0;
    end
    wait_c = (sel_init & ist.powerup) ? WAIT_POWERUP : (pulse_ext + extra);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      reg_select <= sel_rs & ~sel_init;
      nibble     <= nib_c;
      enable     <= en_c;
      wait_us    <= wait_c;
      last       <= cmd.last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/char_lcd_4bit_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// char_lcd_4bit_sequencer_core: 4-bit character LCD pin-phase sequencer
// Turns instruction writes, character writes and initialization requests into
// runs of register select / nibble / enable / hold-time phases.
// ----------------------------------------------------------------------------
//   channel  direction  payload                                   handshake
//   req      in         func, value                               valid/ready
//   phase    out        reg_select, nibble, enable, wait_us, last valid/ready
//   cfg      in         index, data                               valid/ready
//
// One phase leaves per cycle from the output register while phase is not
// stalled; the phase counter runs 4 phases for a byte write, 29 for init.
// A new request is taken after the last phase is loaded and output is free.
// Stalls on phase hold the counter; cfg is always ready.
// rst is synchronous: registers return to post_wait_us 80, pulse_us 1.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_4bit_sequencer_core import lcd4_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  lcd4_req_if.sink     req,
  lcd4_phase_if.source phase,
  lcd4_cfg_if.sink     cfg
);

  lcd4_cmd_t cmd;

  assign cfg.ready = 1'b1;

  lcd4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .out_ready (phase.ready),
    .out_valid (phase.valid),
    .cmd       (cmd)
  );

  lcd4_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .req_func   (req.func),
    .req_value  (req.value),
    .cmd        (cmd),
    .reg_select (phase.reg_select),
    .nibble     (phase.nibble),
    .enable     (phase.enable),
    .wait_us    (phase.wait_us),
    .last       (phase.last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lcd4_chk.sv =====
// ----------------------------------------------------------------------------
// lcd4_chk: port-level checks for the 4-bit character LCD sequencer
// Watches request and phase channels and checks run structure over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_chk import lcd4_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic [1:0]        req_func,
  input wire logic [7:0]        req_value,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_reg_select,
  input wire logic [3:0]        out_nibble,
  input wire logic              out_enable,
  input wire logic [WAIT_W-1:0] out_wait_us,
  input wire logic              out_last
);

  // Stalled phase holds its nibble, enable, wait and last fields
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_nibble) &&
      $stable(out_enable) && $stable(out_wait_us) && $stable(out_last))
    else $error("stalled phase changed");

  // Byte write opens with its upper nibble, enable high
  a_byte_first: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_func == FUNC_INSTR || req_func == FUNC_CHAR)
    |=> out_valid && out_enable && !out_last &&
      out_nibble == $past(req_value[7:4]) && out_reg_select == $past(req_func[0]))
    else $error("byte write did not start with upper nibble");

  // Initialization opens with the power-up hold
  a_init_first: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func == FUNC_INIT
    |=> out_valid && !out_enable && out_wait_us == WAIT_POWERUP && !out_last)
    else $error("initialization did not start with power-up hold");

  // Enable-high phase is followed at once by enable-low on the same nibble
  a_pulse_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_enable
    |-> !out_last ##1 (out_valid && !out_enable && $stable(out_nibble)))
    else $error("enable pulse not closed");

endmodule

bind char_lcd_4bit_sequencer_core lcd4_chk u_lcd4_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_func       (req.func),
  .req_value      (req.value),
  .out_valid      (phase.valid),
  .out_ready      (phase.ready),
  .out_reg_select (phase.reg_select),
  .out_nibble     (phase.nibble),
  .out_enable     (phase.enable),
  .out_wait_us    (phase.wait_us),
  .out_last       (phase.last)
);

`default_nettype wire

// ===== tb/tb_char_lcd_4bit_sequencer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_4bit_sequencer_core: pin-phase checker for the 4-bit LCD sequencer
// Drives instruction, character and initialization requests and register
// writes. Every pin phase that comes out is compared field by field with a
// local phase planner that mirrors both timing registers. A directed table
// comes first, then random traffic under three idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_char_lcd_4bit_sequencer_core;
  import lcd4_pkg::*;

  // Request code the block ignores, and a register index it does not decode
  localparam logic [1:0]             FUNC_NONE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam int QUIET_CYCLES = 8;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 111;
  localparam int N_DIRECTED   = 20;

  typedef struct packed {
    logic              reg_select;
    logic [3:0]        nibble;
    logic              enable;
    logic [WAIT_W-1:0] hold_us;
    logic              last;
  } pin_phase_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [1:0]             func;
    logic [7:0]             value;
    logic                   known;  // tail holds the final phase typed in by hand
    pin_phase_t             tail;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } stim_row_t;

  // Directed table: reset timing first, then zero timing, then the largest
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ROW_REQ, FUNC_INSTR, 8'h00, 1'b1, '{1'b0, 4'h0, 1'b0, 17'd81, 1'b1}, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_CHAR,  8'hFF, 1'b1, '{1'b1, 4'hF, 1'b0, 17'd81, 1'b1}, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_INIT,  8'h00, 1'b1, '{1'b0, 4'hC, 1'b0, 17'd81, 1'b1}, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_INSTR, 8'hA5, 1'b0, '0, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_CHAR,  8'h5A, 1'b0, '0, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_NONE,  8'hFF, 1'b0, '0, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_INIT,  8'hFF, 1'b0, '0, REG_POST_WAIT, 16'h0},
    '{ROW_CFG, FUNC_INSTR, 8'h00, 1'b0, '0, REG_POST_WAIT, 16'h0000},
    '{ROW_CFG, FUNC_INSTR, 8'h00, 1'b0, '0, REG_PULSE,     16'h0000},
    '{ROW_REQ, FUNC_CHAR,  8'h81, 1'b1, '{1'b1, 4'h1, 1'b0, 17'd0, 1'b1}, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_INSTR, 8'h7E, 1'b0, '0, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_INIT,  8'h3C, 1'b1, '{1'b0, 4'hC, 1'b0, 17'd80, 1'b1}, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_NONE,  8'h00, 1'b0, '0, REG_POST_WAIT, 16'h0},
    '{ROW_CFG, FUNC_INSTR, 8'h00, 1'b0, '0, REG_POST_WAIT, 16'hFFFF},
    '{ROW_CFG, FUNC_INSTR, 8'h00, 1'b0, '0, REG_PULSE,     16'hFFFF},
    '{ROW_REQ, FUNC_INSTR, 8'hFF, 1'b1, '{1'b0, 4'hF, 1'b0, 17'd65790, 1'b1}, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_CHAR,  8'h00, 1'b1, '{1'b1, 4'h0, 1'b0, 17'd65790, 1'b1}, REG_POST_WAIT, 16'h0},
    '{ROW_REQ, FUNC_INIT,  8'h00, 1'b1, '{1'b0, 4'hC, 1'b0, 17'd335, 1'b1}, REG_POST_WAIT, 16'h0},
    '{ROW_CFG, FUNC_INSTR, 8'h00, 1'b0, '0, REG_SPARE,     16'h1234},
    '{ROW_REQ, FUNC_CHAR,  8'h3C, 1'b0, '0, REG_POST_WAIT, 16'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  int errors       = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int stall_cycles = 0;

  logic [15:0] post_wait_mirror = POST_WAIT_RESET;
  logic [7:0]  pulse_mirror     = PULSE_RESET;

  pin_phase_t pin_phase_q [$];
  pin_phase_t oldest_phase;

  lcd4_req_if   req_ch ();
  lcd4_phase_if ph_ch ();
  lcd4_cfg_if   cfg_ch ();

  char_lcd_4bit_sequencer_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req_ch),
    .phase (ph_ch),
    .cfg   (cfg_ch)
  );

  always #5 clk = ~clk;

  // Phase planner -----------------------------------------------------------

  function automatic void add_phase(input logic rs, input logic [3:0] nib, input logic en,
                                    input logic [WAIT_W-1:0] hold);
    pin_phase_q.push_back('{rs, nib, en, hold, 1'b0});
  endfunction

  // Enable high, then enable low carrying the extra wait
  function automatic void add_nibble(input logic rs, input logic [3:0] nib,
                                     input logic [WAIT_W-1:0] extra);
    logic [WAIT_W-1:0] pulse;
    pulse = WAIT_W'(pulse_mirror);
    add_phase(rs, nib, 1'b1, pulse);
    add_phase(rs, nib, 1'b0, pulse + extra);
  endfunction

  function automatic void add_byte(input logic rs, input logic [7:0] b,
                                   input logic [WAIT_W-1:0] extra);
    add_nibble(rs, b[7:4], '0);
    add_nibble(rs, b[3:0], extra);
  endfunction

  function automatic void plan_request(input logic [1:0] f, input logic [7:0] v);
    pin_phase_t tail_phase;
    if (f == FUNC_NONE) return;
    if (f == FUNC_INIT) begin
      add_phase(1'b0, 4'h0, 1'b0, WAIT_POWERUP);
      add_nibble(1'b0, CMD_RESET[7:4], WAIT_RESET1);
      add_nibble(1'b0, CMD_RESET[7:4], WAIT_RESET23);
      add_nibble(1'b0, CMD_RESET[7:4], WAIT_RESET23);
      add_nibble(1'b0, CMD_FUNC4BIT[7:4], WAIT_CMD);
      add_byte(1'b0, CMD_FUNC4BIT, WAIT_CMD);
      add_byte(1'b0, CMD_DISP_OFF, WAIT_CMD);
      add_byte(1'b0, CMD_CLEAR, WAIT_CLEAR);
      add_byte(1'b0, CMD_ENTRY, WAIT_CMD);
      add_byte(1'b0, CMD_DISP_ON, WAIT_CMD);
    end else begin
      // register select follows the request: instruction low, character high
      add_byte(f == FUNC_CHAR, v, WAIT_W'(post_wait_mirror));
    end
    // mark the close of the run
    tail_phase = pin_phase_q.pop_back();
    tail_phase.last = 1'b1;
    pin_phase_q.push_back(tail_phase);
  endfunction

  // Drivers -----------------------------------------------------------------

  task automatic send_req(input logic [1:0] f, input logic [7:0] v, input logic known,
                          input pin_phase_t tail);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    plan_request(f, v);
    // a hand-typed final phase stands in for the planned one
    if (known) begin
      void'(pin_phase_q.pop_back());
      pin_phase_q.push_back(tail);
    end
    @(negedge clk);
  endtask

  // Hold requests until every planned phase is out and the block has settled
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pin_phase_q.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_POST_WAIT: post_wait_mirror = d;
      REG_PULSE:     pulse_mirror     = d[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random_phase(input int snd_pct, input int rcv_pct);
    int sent;
    int pick;
    logic [1:0] f;
    sent = 0;
    wait_idle();
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    write_reg(REG_POST_WAIT, 16'($urandom_range(65535)));
    write_reg(REG_PULSE, 16'($urandom_range(65535)));
    write_reg(REG_SPARE, 16'($urandom_range(65535)));
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40) f = FUNC_INSTR;
      else if (pick < 85) f = FUNC_CHAR;
      else if (pick < 93) f = FUNC_INIT;
      else f = FUNC_NONE;
      send_req(f, 8'($urandom_range(255)), 1'b0, '0);
      if (f != FUNC_NONE) sent++;
    end
  endtask

  // Result side -------------------------------------------------------------

  always @(negedge clk) begin
    ph_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic void check_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // Compare each accepted phase with the oldest planned one
  always @(posedge clk) begin
    if (!rst && ph_ch.valid && ph_ch.ready) begin
      if (pin_phase_q.size() == 0) begin
        $error("phase with none expected: rs %0d nibble %0h enable %0d hold %0d last %0d",
               ph_ch.reg_select, ph_ch.nibble, ph_ch.enable, ph_ch.wait_us, ph_ch.last);
        errors++;
      end else begin
        oldest_phase = pin_phase_q.pop_front();
        check_field("reg_select", 32'(oldest_phase.reg_select), 32'(ph_ch.reg_select));
        check_field("nibble", 32'(oldest_phase.nibble), 32'(ph_ch.nibble));
        check_field("enable", 32'(oldest_phase.enable), 32'(ph_ch.enable));
        check_field("wait_us", 32'(oldest_phase.hold_us), 32'(ph_ch.wait_us));
        check_field("last", 32'(oldest_phase.last), 32'(ph_ch.last));
      end
    end
  end

  // Stop a hung run: count cycles in which no channel moves an item
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (ph_ch.valid && ph_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus ----------------------------------------------------------------

  initial begin
    stim_row_t row;
    req_ch.valid = 1'b0;
    req_ch.func  = FUNC_INSTR;
    req_ch.value = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_POST_WAIT;
    cfg_ch.data  = '0;
    ph_ch.ready  = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    snd_idle_pct = 17;
    rcv_idle_pct = 85;
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.index, row.data);
      end else begin
        send_req(row.func, row.value, row.known, row.tail);
      end
    end

    run_random_phase(17, 85);
    run_random_phase(85, 17);
    run_random_phase(0, 0);

    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lcd4_pkg.sv
hw/rtl/lcd4_ifs.sv
hw/rtl/lcd4_ctrl.sv
hw/rtl/lcd4_dp.sv
hw/rtl/char_lcd_4bit_sequencer_core.sv
hw/rtl/lcd4_chk.sv
tb/tb_char_lcd_4bit_sequencer_core.sv
